@@ rtl/prps_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// prps_pkg
// Shared types, register indexes, codes and reset values of the power rail
// protection supervisor.
// ----------------------------------------------------------------------------
package prps_pkg;

    localparam int unsigned DATA_W    = 16;
    localparam int unsigned CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_VOLT16    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WARN_VOLT16   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_VOLT32    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WARN_VOLT32   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CURRENT16 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CURRENT32 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TRIP_DELAY    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_WARN_INTERVAL = 3'd7;

    // register reset values
    localparam logic signed [DATA_W-1:0] RST_MIN_VOLT16    = 16'sd13312;
    localparam logic signed [DATA_W-1:0] RST_WARN_VOLT16   = 16'sd14336;
    localparam logic signed [DATA_W-1:0] RST_MIN_VOLT32    = 16'sd26624;
    localparam logic signed [DATA_W-1:0] RST_WARN_VOLT32   = 16'sd28672;
    localparam logic signed [DATA_W-1:0] RST_MAX_CURRENT16 = 16'sd10240;
    localparam logic signed [DATA_W-1:0] RST_MAX_CURRENT32 = 16'sd20480;
    localparam logic [DATA_W-1:0]        RST_TRIP_DELAY    = 16'd10;
    localparam logic [DATA_W-1:0]        RST_WARN_INTERVAL = 16'd250;

    // item kinds
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_CMD  = 1'b1;

    // command targets
    localparam logic [1:0] SEL_RAIL16 = 2'd0;
    localparam logic [1:0] SEL_RAIL32 = 2'd1;
    localparam logic [1:0] SEL_BOTH   = 2'd2;

    // command actions
    localparam logic ACT_OFF = 1'b0;
    localparam logic ACT_ON  = 1'b1;

    // rail flag positions
    localparam int unsigned FLAG16_BIT = 0;
    localparam int unsigned FLAG32_BIT = 1;
    localparam logic [1:0]  FLAGS_NONE = 2'b00;
    localparam logic [1:0]  FLAGS_BOTH = 2'b11;

    typedef struct packed {
        logic signed [DATA_W-1:0] min_volt16;
        logic signed [DATA_W-1:0] warn_volt16;
        logic signed [DATA_W-1:0] min_volt32;
        logic signed [DATA_W-1:0] warn_volt32;
        logic signed [DATA_W-1:0] max_current16;
        logic signed [DATA_W-1:0] max_current32;
        logic [DATA_W-1:0]        trip_delay;
        logic [DATA_W-1:0]        warn_interval;
    } cfg_t;

    typedef struct packed {
        logic                     kind;
        logic [1:0]               rail_select;
        logic                     action;
        logic signed [DATA_W-1:0] volt16_a;
        logic signed [DATA_W-1:0] volt16_b;
        logic signed [DATA_W-1:0] volt16_c;
        logic signed [DATA_W-1:0] volt32_a;
        logic signed [DATA_W-1:0] volt32_b;
        logic signed [DATA_W-1:0] volt32_c;
        logic signed [DATA_W-1:0] current16;
        logic signed [DATA_W-1:0] current32;
    } item_t;

    typedef struct packed {
        logic       rail16_enable;
        logic       rail32_enable;
        logic [1:0] off_tones;
        logic       on_tones;
        logic       low_power_tone;
    } res_t;

    function automatic logic signed [DATA_W-1:0] max3(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b,
        input logic signed [DATA_W-1:0] c
    );
        logic signed [DATA_W-1:0] m;
        m = a;
        if (b > m) m = b;
        if (c > m) m = c;
        return m;
    endfunction

endpackage
`default_nettype wire

@@ rtl/power_rail_protection_supervisor_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// power_rail_protection_supervisor_unit
// Switch control and protection of a 16 V and a 32 V supply rail.
// ----------------------------------------------------------------------------
// Usage:
//   s_* is a valid/ready channel carrying either a rail command or a
//   measurement tick; m_* returns one result per transfer with the rail
//   switch states and the tones that the item asked for.
//   Thresholds, current limits, trip delay and warning interval are set via
//   cfg_wr_en/cfg_index/cfg_wdata; write them only while the block is idle.
//   Each item passes through the input register, then the result register,
//   which drives m_valid. Throughput: one item per cycle while m_ready is high,
//   since each item is evaluated in a single pass against the current rail state.
//   When m_ready is low the result register holds; the input register still
//   takes one further item, and s_ready then drops until the result drains.
//   Reset clears both rails to off, the warning and trip counters, and
//   reloads the default thresholds; no result is pending after reset.
// ----------------------------------------------------------------------------
module power_rail_protection_supervisor_unit
    import prps_pkg::*;
(
    input  wire logic                        aclk,
    input  wire logic                        aresetn,

    input  wire logic                        cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [DATA_W-1:0]           cfg_wdata,

    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic                        s_kind,
    input  wire logic [1:0]                  s_rail_select,
    input  wire logic                        s_action,
    input  wire logic signed [DATA_W-1:0]    s_volt16_a,
    input  wire logic signed [DATA_W-1:0]    s_volt16_b,
    input  wire logic signed [DATA_W-1:0]    s_volt16_c,
    input  wire logic signed [DATA_W-1:0]    s_volt32_a,
    input  wire logic signed [DATA_W-1:0]    s_volt32_b,
    input  wire logic signed [DATA_W-1:0]    s_volt32_c,
    input  wire logic signed [DATA_W-1:0]    s_current16,
    input  wire logic signed [DATA_W-1:0]    s_current32,

    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic                             m_rail16_enable,
    output logic                             m_rail32_enable,
    output logic [1:0]                       m_off_tones,
    output logic                             m_on_tones,
    output logic                             m_low_power_tone
);

    cfg_t  cfg;
    item_t s_item;
    item_t in_item_reg;
    logic  in_valid_reg, in_valid_next;
    res_t  eval_res;
    res_t  out_res_reg;
    logic  out_valid_reg, out_valid_next;
    logic  advance;
    logic  in_xfer;

    assign s_item.kind        = s_kind;
    assign s_item.rail_select = s_rail_select;
    assign s_item.action      = s_action;
    assign s_item.volt16_a    = s_volt16_a;
    assign s_item.volt16_b    = s_volt16_b;
    assign s_item.volt16_c    = s_volt16_c;
    assign s_item.volt32_a    = s_volt32_a;
    assign s_item.volt32_b    = s_volt32_b;
    assign s_item.volt32_c    = s_volt32_c;
    assign s_item.current16   = s_current16;
    assign s_item.current32   = s_current32;

    prps_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    prps_eval u_eval (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (eval_res)
    );

    // item moves to the result register when that register is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign in_xfer = s_valid && s_ready;

    always_comb begin
        in_valid_next  = in_xfer || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            out_res_reg <= eval_res;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_rail16_enable  = out_res_reg.rail16_enable;
    assign m_rail32_enable  = out_res_reg.rail32_enable;
    assign m_off_tones      = out_res_reg.off_tones;
    assign m_on_tones       = out_res_reg.on_tones;
    assign m_low_power_tone = out_res_reg.low_power_tone;

endmodule
`default_nettype wire

@@ rtl/prps_cfg_regs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// prps_cfg_regs
// Threshold, limit and interval registers written through the plain write port.
// ----------------------------------------------------------------------------
module prps_cfg_regs
    import prps_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0]    cfg_wdata,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MIN_VOLT16:    cfg_next.min_volt16    = $signed(cfg_wdata);
                REG_WARN_VOLT16:   cfg_next.warn_volt16   = $signed(cfg_wdata);
                REG_MIN_VOLT32:    cfg_next.min_volt32    = $signed(cfg_wdata);
                REG_WARN_VOLT32:   cfg_next.warn_volt32   = $signed(cfg_wdata);
                REG_MAX_CURRENT16: cfg_next.max_current16 = $signed(cfg_wdata);
                REG_MAX_CURRENT32: cfg_next.max_current32 = $signed(cfg_wdata);
                REG_TRIP_DELAY:    cfg_next.trip_delay    = cfg_wdata;
                REG_WARN_INTERVAL: cfg_next.warn_interval = cfg_wdata;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_volt16    <= RST_MIN_VOLT16;
            cfg_reg.warn_volt16   <= RST_WARN_VOLT16;
            cfg_reg.min_volt32    <= RST_MIN_VOLT32;
            cfg_reg.warn_volt32   <= RST_WARN_VOLT32;
            cfg_reg.max_current16 <= RST_MAX_CURRENT16;
            cfg_reg.max_current32 <= RST_MAX_CURRENT32;
            cfg_reg.trip_delay    <= RST_TRIP_DELAY;
            cfg_reg.warn_interval <= RST_WARN_INTERVAL;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

@@ rtl/prps_eval.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// prps_eval
// Rail state, warning and trip counters, and the single-pass decision logic
// for one command or measurement tick.
// ----------------------------------------------------------------------------
module prps_eval
    import prps_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  step,
    input  wire item_t item,
    input  wire cfg_t  cfg,
    output res_t       res
);

    logic [1:0]        rail_flags_reg,   rail_flags_next;
    logic [DATA_W-1:0] warn_counter_reg, warn_counter_next;
    logic [DATA_W-1:0] trip_count16_reg, trip_count16_next;
    logic [DATA_W-1:0] trip_count32_reg, trip_count32_next;

    logic signed [DATA_W-1:0] v16;
    logic signed [DATA_W-1:0] v32;
    logic                     on16;
    logic                     on32;
    logic [1:0]               off_cnt;
    logic                     on_cnt;
    logic                     low_tone;

    assign v16  = max3(item.volt16_a, item.volt16_b, item.volt16_c);
    assign v32  = max3(item.volt32_a, item.volt32_b, item.volt32_c);
    assign on16 = rail_flags_reg[FLAG16_BIT];
    assign on32 = rail_flags_reg[FLAG32_BIT];

    always_comb begin
        rail_flags_next   = rail_flags_reg;
        warn_counter_next = warn_counter_reg;
        trip_count16_next = trip_count16_reg;
        trip_count32_next = trip_count32_reg;
        off_cnt           = 2'd0;
        on_cnt            = 1'b0;
        low_tone          = 1'b0;

        if (item.kind == KIND_CMD) begin
            case (item.rail_select) inside
                SEL_RAIL16, SEL_BOTH: begin
                    if (item.action == ACT_ON) begin
                        rail_flags_next = FLAGS_BOTH;
                        on_cnt          = 1'b1;
                    end else begin
                        rail_flags_next = FLAGS_NONE;
                        off_cnt         = 2'd1;
                    end
                end
                SEL_RAIL32: begin
                    rail_flags_next[FLAG32_BIT] = (item.action == ACT_ON);
                    if (item.action == ACT_ON) begin
                        on_cnt = 1'b1;
                    end else begin
                        off_cnt = 2'd1;
                    end
                end
                default: begin
                    rail_flags_next = rail_flags_reg;
                end
            endcase
        end else begin
            // undervoltage first, then low-voltage warning
            if (on16 && v16 <= cfg.min_volt16) begin
                rail_flags_next   = FLAGS_NONE;
                off_cnt           = off_cnt + 2'd1;
                warn_counter_next = '0;
            end else if (on32 && v32 <= cfg.min_volt32) begin
                rail_flags_next[FLAG32_BIT] = 1'b0;
                off_cnt                     = off_cnt + 2'd1;
            end else if ((on16 && v16 <= cfg.warn_volt16) ||
                         (on32 && v32 <= cfg.warn_volt32)) begin
                if (warn_counter_reg >= cfg.warn_interval) begin
                    low_tone          = 1'b1;
                    warn_counter_next = '0;
                end else begin
                    warn_counter_next = warn_counter_reg + 16'd1;
                end
            end else begin
                warn_counter_next = '0;
            end

            // 16 V overcurrent trips both rails
            if (item.current16 > cfg.max_current16) begin
                if (trip_count16_reg >= cfg.trip_delay) begin
                    rail_flags_next = FLAGS_NONE;
                    off_cnt         = off_cnt + 2'd1;
                end else begin
                    trip_count16_next = trip_count16_reg + 16'd1;
                end
            end else begin
                trip_count16_next = '0;
            end

            // 32 V overcurrent, or re-enable when only the 16 V rail is on
            if (item.current32 > cfg.max_current32) begin
                if (trip_count32_reg >= cfg.trip_delay) begin
                    rail_flags_next[FLAG32_BIT] = 1'b0;
                    off_cnt                     = off_cnt + 2'd1;
                end else begin
                    trip_count32_next = trip_count32_reg + 16'd1;
                end
            end else begin
                trip_count32_next = '0;
                if (rail_flags_next[FLAG16_BIT] && !rail_flags_next[FLAG32_BIT]) begin
                    rail_flags_next[FLAG32_BIT] = 1'b1;
                    on_cnt                      = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rail_flags_reg   <= FLAGS_NONE;
            warn_counter_reg <= '0;
            trip_count16_reg <= '0;
            trip_count32_reg <= '0;
        end else if (step) begin
            rail_flags_reg   <= rail_flags_next;
            warn_counter_reg <= warn_counter_next;
            trip_count16_reg <= trip_count16_next;
            trip_count32_reg <= trip_count32_next;
        end
    end

    assign res.rail16_enable  = rail_flags_next[FLAG16_BIT];
    assign res.rail32_enable  = rail_flags_next[FLAG32_BIT];
    assign res.off_tones      = off_cnt;
    assign res.on_tones       = on_cnt;
    assign res.low_power_tone = low_tone;

    // a full switch-on command leaves both rails on
    a_cmd_both_on : assert property (@(posedge aclk) disable iff (!aresetn)
        step && item.kind == KIND_CMD && item.action == ACT_ON &&
        (item.rail_select == SEL_RAIL16 || item.rail_select == SEL_BOTH)
        |=> rail_flags_reg == FLAGS_BOTH)
        else $error("switch-on of both rails did not take effect");

    // 16 V undervoltage clears the warning count
    a_uv16_clears_warn : assert property (@(posedge aclk) disable iff (!aresetn)
        step && item.kind == KIND_TICK && on16 && v16 <= cfg.min_volt16
        |=> warn_counter_reg == '0)
        else $error("warning count survived 16 V undervoltage");

    // an on tone always leaves the 32 V rail on
    a_on_tone_rail32 : assert property (@(posedge aclk) disable iff (!aresetn)
        res.on_tones |-> res.rail32_enable)
        else $error("on tone without the 32 V rail on");

    // state only moves when an item is processed
    a_state_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(rail_flags_reg) && $stable(warn_counter_reg))
        else $error("rail state changed without an item");

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the power rail protection supervisor. A directed
// run covers the rail commands, undervoltage, trips and tone counts. Random
// bursts then switch the rails on and feed ticks whose voltages and currents
// sit near the programmed levels, under several register settings. Each
// result is checked against a predicted rail state and tone set.
// ----------------------------------------------------------------------------
module tb
    import prps_pkg::*;
();

    localparam int         CYCLE_LIMIT = 600000;
    localparam int         PHASE_ITEMS = 255;
    localparam logic [1:0] SEL_NONE    = 2'd3;

    typedef enum int {BAND_NORMAL, BAND_WARN, BAND_EDGE, BAND_UNDER, BAND_ANY} volt_band_t;
    typedef enum int {LOAD_BELOW, LOAD_OVER, LOAD_ANY} load_band_t;

    class rail_scoreboard;
        cfg_t        cfg;
        logic [1:0]  rails;
        logic [15:0] warn_count;
        logic [15:0] trip16_count;
        logic [15:0] trip32_count;
        res_t        expected_rails[$];
        int unsigned mismatches;

        function new();
            cfg.min_volt16    = RST_MIN_VOLT16;
            cfg.warn_volt16   = RST_WARN_VOLT16;
            cfg.min_volt32    = RST_MIN_VOLT32;
            cfg.warn_volt32   = RST_WARN_VOLT32;
            cfg.max_current16 = RST_MAX_CURRENT16;
            cfg.max_current32 = RST_MAX_CURRENT32;
            cfg.trip_delay    = RST_TRIP_DELAY;
            cfg.warn_interval = RST_WARN_INTERVAL;
            rails        = FLAGS_NONE;
            warn_count   = '0;
            trip16_count = '0;
            trip32_count = '0;
            mismatches   = 0;
        endfunction

        function logic signed [DATA_W-1:0] peak3(logic signed [DATA_W-1:0] a,
                                                 logic signed [DATA_W-1:0] b,
                                                 logic signed [DATA_W-1:0] c);
            logic signed [DATA_W-1:0] m;
            m = a;
            if (b > m) m = b;
            if (c > m) m = c;
            return m;
        endfunction

        function res_t predict_rails(item_t it);
            res_t                     r;
            logic signed [DATA_W-1:0] v16;
            logic signed [DATA_W-1:0] v32;
            logic                     on16;
            logic                     on32;
            r = '0;
            if (it.kind == KIND_CMD) begin
                if (it.rail_select == SEL_RAIL16 || it.rail_select == SEL_BOTH) begin
                    rails = (it.action == ACT_ON) ? FLAGS_BOTH : FLAGS_NONE;
                    if (it.action == ACT_ON) r.on_tones = r.on_tones + 1'b1;
                    else r.off_tones = r.off_tones + 2'd1;
                end else if (it.rail_select == SEL_RAIL32) begin
                    rails[FLAG32_BIT] = it.action;
                    if (it.action == ACT_ON) r.on_tones = r.on_tones + 1'b1;
                    else r.off_tones = r.off_tones + 2'd1;
                end
            end else begin
                v16  = peak3(it.volt16_a, it.volt16_b, it.volt16_c);
                v32  = peak3(it.volt32_a, it.volt32_b, it.volt32_c);
                on16 = rails[FLAG16_BIT];
                on32 = rails[FLAG32_BIT];
                // 16 V undervoltage wins over 32 V undervoltage and the warning, and clears the warning
                if (on16 && v16 <= $signed(cfg.min_volt16)) begin
                    rails      = FLAGS_NONE;
                    r.off_tones = r.off_tones + 2'd1;
                    warn_count = '0;
                end else if (on32 && v32 <= $signed(cfg.min_volt32)) begin
                    rails[FLAG32_BIT] = 1'b0;
                    r.off_tones = r.off_tones + 2'd1;
                end else if ((on16 && v16 <= $signed(cfg.warn_volt16)) ||
                             (on32 && v32 <= $signed(cfg.warn_volt32))) begin
                    if (warn_count >= cfg.warn_interval) begin
                        r.low_power_tone = 1'b1;
                        warn_count       = '0;
                    end else begin
                        warn_count = warn_count + 16'd1;
                    end
                end else begin
                    warn_count = '0;
                end

                if ($signed(it.current16) > $signed(cfg.max_current16)) begin
                    if (trip16_count >= cfg.trip_delay) begin
                        rails       = FLAGS_NONE;
                        r.off_tones = r.off_tones + 2'd1;
                    end else begin
                        trip16_count = trip16_count + 16'd1;
                    end
                end else begin
                    trip16_count = '0;
                end

                if ($signed(it.current32) > $signed(cfg.max_current32)) begin
                    if (trip32_count >= cfg.trip_delay) begin
                        rails[FLAG32_BIT] = 1'b0;
                        r.off_tones = r.off_tones + 2'd1;
                    end else begin
                        trip32_count = trip32_count + 16'd1;
                    end
                end else begin
                    trip32_count = '0;
                    // 32 V rail returns while the 16 V rail is up
                    if (rails[FLAG16_BIT] && !rails[FLAG32_BIT]) begin
                        rails[FLAG32_BIT] = 1'b1;
                        r.on_tones = r.on_tones + 1'b1;
                    end
                end
            end
            r.rail16_enable = rails[FLAG16_BIT];
            r.rail32_enable = rails[FLAG32_BIT];
            return r;
        endfunction

        function void note_item(item_t it);
            expected_rails.push_back(predict_rails(it));
        endfunction

        function void compare_field(string field, int want, int got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (expected_rails.size() == 0) begin
                $display("%0t: result with nothing expected, expected none actual %b",
                         $time, got);
                mismatches++;
                return;
            end
            want = expected_rails.pop_front();
            compare_field("rail16_enable", int'(want.rail16_enable), int'(got.rail16_enable));
            compare_field("rail32_enable", int'(want.rail32_enable), int'(got.rail32_enable));
            compare_field("off_tones", int'(want.off_tones), int'(got.off_tones));
            compare_field("on_tones", int'(want.on_tones), int'(got.on_tones));
            compare_field("low_power_tone", int'(want.low_power_tone),
                          int'(got.low_power_tone));
        endfunction
    endclass

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_wr_en;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [DATA_W-1:0]        cfg_wdata;
    logic                     s_valid;
    logic                     s_ready;
    logic                     s_kind;
    logic [1:0]               s_rail_select;
    logic                     s_action;
    logic signed [DATA_W-1:0] s_volt16_a;
    logic signed [DATA_W-1:0] s_volt16_b;
    logic signed [DATA_W-1:0] s_volt16_c;
    logic signed [DATA_W-1:0] s_volt32_a;
    logic signed [DATA_W-1:0] s_volt32_b;
    logic signed [DATA_W-1:0] s_volt32_c;
    logic signed [DATA_W-1:0] s_current16;
    logic signed [DATA_W-1:0] s_current32;
    logic                     m_valid;
    logic                     m_ready;
    logic                     m_rail16_enable;
    logic                     m_rail32_enable;
    logic [1:0]               m_off_tones;
    logic                     m_on_tones;
    logic                     m_low_power_tone;

    rail_scoreboard sb;
    int             items_sent  = 0;
    int             cycle_count = 0;
    bit             tx_calm     = 1'b0;
    bit             rx_calm     = 1'b0;

    power_rail_protection_supervisor_unit i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_rail_select    (s_rail_select),
        .s_action         (s_action),
        .s_volt16_a       (s_volt16_a),
        .s_volt16_b       (s_volt16_b),
        .s_volt16_c       (s_volt16_c),
        .s_volt32_a       (s_volt32_a),
        .s_volt32_b       (s_volt32_b),
        .s_volt32_c       (s_volt32_c),
        .s_current16      (s_current16),
        .s_current32      (s_current32),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_rail16_enable  (m_rail16_enable),
        .m_rail32_enable  (m_rail32_enable),
        .m_off_tones      (m_off_tones),
        .m_on_tones       (m_on_tones),
        .m_low_power_tone (m_low_power_tone)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result({m_rail16_enable, m_rail32_enable, m_off_tones,
                             m_on_tones, m_low_power_tone});
        end
    end

    function automatic int idle_gap(bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side: random stalls, with calm stretches
    initial begin
        int stall;
        stall   = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 199) == 0) rx_calm = !rx_calm;
                if (!rx_calm && $urandom_range(0, 2) == 0) stall = idle_gap(1'b0);
            end
        end
    end

    function automatic int clamp16(int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic int pick(int lo, int hi);
        if (hi < lo) return hi;
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic int any16();
        logic signed [DATA_W-1:0] v;
        v = 16'($urandom);
        return int'(v);
    endfunction

    function automatic volt_band_t any_volt_band();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return BAND_NORMAL;
        if (r < 65) return BAND_WARN;
        if (r < 80) return BAND_EDGE;
        if (r < 90) return BAND_UNDER;
        return BAND_ANY;
    endfunction

    function automatic load_band_t any_load_band();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return LOAD_BELOW;
        if (r < 92) return LOAD_OVER;
        return LOAD_ANY;
    endfunction

    function automatic int volt_level(volt_band_t b, int cutoff, int warn);
        case (b)
            BAND_NORMAL: return pick(warn + 1, clamp16(warn + 3000));
            BAND_WARN:   return pick(clamp16(cutoff + 1), warn);
            BAND_EDGE: begin
                case ($urandom_range(0, 3))
                    0:       return cutoff;
                    1:       return clamp16(cutoff + 1);
                    2:       return warn;
                    default: return clamp16(warn + 1);
                endcase
            end
            BAND_UNDER:  return pick(clamp16(cutoff - 3000), cutoff);
            default:     return any16();
        endcase
    endfunction

    function automatic int load_level(load_band_t b, int limit);
        case (b)
            LOAD_BELOW: return pick(clamp16(limit - 3000), limit);
            LOAD_OVER:  return pick(limit + 1, clamp16(limit + 3000));
            default:    return any16();
        endcase
    endfunction

    // three samples whose highest is the given level
    function automatic void spread3(int peak_level, output logic signed [DATA_W-1:0] v[3]);
        int slot;
        slot = $urandom_range(0, 2);
        for (int k = 0; k < 3; k++) begin
            if (k == slot) v[k] = 16'(peak_level);
            else if ($urandom_range(0, 4) == 0) v[k] = 16'(pick(-32768, peak_level));
            else v[k] = 16'(pick(clamp16(peak_level - 2000), peak_level));
        end
    endfunction

    function automatic item_t random_item();
        item_t it;
        it.kind        = 1'($urandom);
        it.rail_select = 2'($urandom);
        it.action      = 1'($urandom);
        it.volt16_a    = 16'($urandom);
        it.volt16_b    = 16'($urandom);
        it.volt16_c    = 16'($urandom);
        it.volt32_a    = 16'($urandom);
        it.volt32_b    = 16'($urandom);
        it.volt32_c    = 16'($urandom);
        it.current16   = 16'($urandom);
        it.current32   = 16'($urandom);
        return it;
    endfunction

    function automatic item_t rail_command(logic [1:0] sel, logic act);
        item_t it;
        it             = random_item();
        it.kind        = KIND_CMD;
        it.rail_select = sel;
        it.action      = act;
        return it;
    endfunction

    function automatic item_t flat_tick(int v16, int v32, int c16, int c32);
        item_t it;
        it           = random_item();
        it.kind      = KIND_TICK;
        it.volt16_a  = 16'(v16);
        it.volt16_b  = 16'(v16);
        it.volt16_c  = 16'(v16);
        it.volt32_a  = 16'(v32);
        it.volt32_b  = 16'(v32);
        it.volt32_c  = 16'(v32);
        it.current16 = 16'(c16);
        it.current32 = 16'(c32);
        return it;
    endfunction

    function automatic item_t rail_tick(volt_band_t b16, volt_band_t b32,
                                        load_band_t l16, load_band_t l32);
        item_t                    it;
        logic signed [DATA_W-1:0] v[3];
        it      = random_item();
        it.kind = KIND_TICK;
        spread3(volt_level(b16, int'($signed(sb.cfg.min_volt16)),
                           int'($signed(sb.cfg.warn_volt16))), v);
        it.volt16_a = v[0];
        it.volt16_b = v[1];
        it.volt16_c = v[2];
        spread3(volt_level(b32, int'($signed(sb.cfg.min_volt32)),
                           int'($signed(sb.cfg.warn_volt32))), v);
        it.volt32_a  = v[0];
        it.volt32_b  = v[1];
        it.volt32_c  = v[2];
        it.current16 = 16'(load_level(l16, int'($signed(sb.cfg.max_current16))));
        it.current32 = 16'(load_level(l32, int'($signed(sb.cfg.max_current32))));
        return it;
    endfunction

    task automatic drive_item(item_t it);
        s_kind        <= it.kind;
        s_rail_select <= it.rail_select;
        s_action      <= it.action;
        s_volt16_a    <= it.volt16_a;
        s_volt16_b    <= it.volt16_b;
        s_volt16_c    <= it.volt16_c;
        s_volt32_a    <= it.volt32_a;
        s_volt32_b    <= it.volt32_b;
        s_volt32_c    <= it.volt32_c;
        s_current16   <= it.current16;
        s_current32   <= it.current32;
    endtask

    // called at a falling edge; returns at a falling edge
    task automatic send_item(item_t it);
        int gap;
        drive_item(it);
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(it);
        if (!(it.kind == KIND_CMD && it.rail_select == SEL_NONE)) items_sent++;
        @(negedge aclk);
        gap = idle_gap(tx_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.expected_rails.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic load_settings(cfg_t c);
        logic [CFG_IDX_W-1:0] regs [8];
        logic [DATA_W-1:0]    vals [8];
        regs = '{REG_MIN_VOLT16, REG_WARN_VOLT16, REG_MIN_VOLT32, REG_WARN_VOLT32,
                 REG_MAX_CURRENT16, REG_MAX_CURRENT32, REG_TRIP_DELAY, REG_WARN_INTERVAL};
        vals = '{c.min_volt16, c.warn_volt16, c.min_volt32, c.warn_volt32,
                 c.max_current16, c.max_current32, c.trip_delay, c.warn_interval};
        for (int i = 0; i < 8; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= regs[i];
            cfg_wdata <= vals[i];
            @(negedge aclk);
        end
        cfg_wr_en <= 1'b0;
        sb.cfg = c;
    endtask

    task automatic run_directed();
        // rails off: a tick does nothing
        send_item(flat_tick(32767, 32767, -32768, -32768));
        // 32 V alone comes on while the 16 V rail is off
        send_item(rail_command(SEL_RAIL32, ACT_ON));
        send_item(rail_command(SEL_NONE, ACT_ON));
        send_item(rail_command(SEL_RAIL16, ACT_OFF));
        // off tone even though both rails are already off
        send_item(rail_command(SEL_RAIL16, ACT_OFF));
        send_item(rail_command(SEL_BOTH, ACT_ON));
        send_item(flat_tick(16384, 30720, 0, 0));
        // 32 V undervoltage, back on within the same tick
        send_item(flat_tick(16384, 20000, 0, 0));
        send_item(rail_command(SEL_RAIL32, ACT_OFF));
        send_item(flat_tick(16384, 30720, 0, 0));
        send_item(flat_tick(14000, 30720, 0, 0));
        // sustained overcurrent on both rails up to the trip delay
        repeat (10) send_item(flat_tick(16384, 30720, 32767, 32767));
        // undervoltage and both trips together: three off tones
        send_item(flat_tick(-32768, -32768, 32767, 32767));
        send_item(rail_command(SEL_BOTH, ACT_OFF));
        send_item(rail_command(SEL_RAIL16, ACT_ON));
        send_item(flat_tick(-32768, 32767, -32768, 32767));
    endtask

    task automatic run_burst();
        volt_band_t b16;
        volt_band_t b32;
        load_band_t l16;
        load_band_t l32;
        item_t      it;
        int         len;
        int         r;
        if ($urandom_range(0, 6) == 0) tx_calm = !tx_calm;
        if ($urandom_range(0, 9) != 0) begin
            send_item(rail_command($urandom_range(0, 1) ? SEL_BOTH : SEL_RAIL16, ACT_ON));
        end else begin
            send_item(rail_command(2'($urandom_range(0, 3)), 1'($urandom)));
        end
        b16 = any_volt_band();
        b32 = any_volt_band();
        l16 = any_load_band();
        l32 = any_load_band();
        len = $urandom_range(2, 30);
        repeat (len) begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
                send_item(rail_command(2'($urandom_range(0, 3)), 1'($urandom)));
            end else if (r < 8) begin
                it      = random_item();
                it.kind = KIND_TICK;
                send_item(it);
            end else begin
                if (r < 12) b16 = any_volt_band();
                else if (r < 16) b32 = any_volt_band();
                else if (r < 19) l16 = any_load_band();
                else if (r < 22) l32 = any_load_band();
                send_item(rail_tick(b16, b32, l16, l32));
            end
        end
    endtask

    task automatic run_phase(int n);
        int first;
        first = items_sent;
        while (items_sent - first < n) begin
            run_burst();
            if ($urandom_range(0, 19) == 0) drain();
        end
    endtask

    initial begin
        cfg_t c;
        sb        = new();
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        drive_item('0);
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        run_directed();
        run_phase(PHASE_ITEMS);

        // short delays and intervals at the default levels
        c               = sb.cfg;
        c.trip_delay    = 16'd2;
        c.warn_interval = 16'd3;
        drain();
        load_settings(c);
        run_phase(PHASE_ITEMS);

        // lowest cutoffs, highest warnings, immediate trips and tones
        c.min_volt16    = -16'sd32768;
        c.warn_volt16   = 16'sd32767;
        c.min_volt32    = -16'sd32768;
        c.warn_volt32   = 16'sd32767;
        c.max_current16 = -16'sd32768;
        c.max_current32 = 16'sd32767;
        c.trip_delay    = 16'd0;
        c.warn_interval = 16'd0;
        drain();
        load_settings(c);
        run_phase(PHASE_ITEMS);

        c.min_volt16    = -16'sd32768;
        c.warn_volt16   = -16'sd32768;
        c.min_volt32    = 16'sd32767;
        c.warn_volt32   = 16'sd32767;
        c.max_current16 = 16'sd32767;
        c.max_current32 = -16'sd32768;
        c.trip_delay    = 16'hFFFF;
        c.warn_interval = 16'hFFFF;
        drain();
        load_settings(c);
        run_phase(PHASE_ITEMS);

        // lowered limits take effect on counts already built up
        c.min_volt16    = 16'(pick(8000, 16000));
        c.warn_volt16   = 16'(clamp16(int'($signed(c.min_volt16)) + pick(0, 2000)));
        c.min_volt32    = 16'(pick(20000, 28000));
        c.warn_volt32   = 16'(clamp16(int'($signed(c.min_volt32)) + pick(0, 3000)));
        c.max_current16 = 16'(pick(-1000, 20000));
        c.max_current32 = 16'(pick(-1000, 30000));
        c.trip_delay    = 16'(pick(0, 15));
        c.warn_interval = 16'(pick(0, 7));
        drain();
        load_settings(c);
        run_phase(PHASE_ITEMS);

        drain();
        repeat (10) @(negedge aclk);
        if (sb.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
